FILE: sv/lsfe_pkg.sv
// Shared types and constants for the LED strip frame encoder.
// Used by every module of the block.
package lsfe_pkg;

    // Frame geometry.
    localparam int START_BYTES = 4;
    localparam int END_BYTES   = 56;
    localparam int LED_BYTES   = 4;

    // The byte counter of the sequencer covers the longest phase.
    localparam int CNT_MAX_A = (START_BYTES > LED_BYTES) ? START_BYTES : LED_BYTES;
    localparam int CNT_MAX   = (END_BYTES > CNT_MAX_A) ? END_BYTES : CNT_MAX_A;
    localparam int CNT_W     = (CNT_MAX > 1) ? $clog2(CNT_MAX) : 1;
    localparam int END_LAST  = (END_BYTES > 0) ? END_BYTES - 1 : 0;

    // Byte constants of the LED frame format.
    localparam logic [7:0] TOP_KEEP_MASK = 8'hE0;
    localparam logic [4:0] BRIGHT_MASK   = 5'h1F;
    localparam logic [7:0] BLANK_TOP     = 8'b1110_0001;
    localparam logic [7:0] FILL_RESET    = 8'hFF;

    // Command queue between the front and the back.
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_START_WORD = 2'd0,
        REG_BRIGHTNESS = 2'd1,
        REG_BLANK_MODE = 2'd2,
        REG_END_FILL   = 2'd3
    } cfg_reg_t;

    // Input item kinds.
    localparam logic KIND_LED   = 1'b0;
    localparam logic KIND_EMPTY = 1'b1;

    // Live configuration as seen by the datapath.
    typedef struct packed {
        logic [31:0] start_word;
        logic [4:0]  brightness;
        logic        blank_mode;
        logic [7:0]  end_fill;
    } cfg_t;

    // Classified item: which phases to run and the finished LED bytes.
    typedef struct packed {
        logic        has_start;
        logic        has_led;
        logic        has_end;
        logic [31:0] led_bytes;
    } cmd_t;

endpackage

FILE: sv/lsfe_item_if.sv
// Input channel of the LED strip frame encoder: one LED word or empty frame.
// Depends on nothing but the valid/ready handshake.
interface lsfe_item_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] led_word;
    logic        first_led;
    logic        last_led;

    modport source (output valid, kind, led_word, first_led, last_led, input ready);
    modport sink   (input valid, kind, led_word, first_led, last_led, output ready);
endinterface

FILE: sv/lsfe_byte_if.sv
// Output channel of the LED strip frame encoder: one serial byte per word.
// Depends on nothing but the valid/ready handshake.
interface lsfe_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_end;

    modport source (output valid, out_byte, frame_end, input ready);
    modport sink   (input valid, out_byte, frame_end, output ready);
endinterface

FILE: sv/lsfe_cfg_if.sv
// Configuration write channel of the LED strip frame encoder.
// Carries a register index and 32 bits of write data.
interface lsfe_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/lsfe_cfg_regs.sv
// Configuration register file of the LED strip frame encoder.
// Depends on lsfe_pkg and lsfe_cfg_if.
module lsfe_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    lsfe_cfg_if.sink          cfg,
    output lsfe_pkg::cfg_t    cfg_q
);
    import lsfe_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    // Writes are always accepted.
    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid;

    // Decode the register index and merge the write data.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_START_WORD: cfg_next.start_word = cfg.data;
                REG_BRIGHTNESS: cfg_next.brightness = cfg.data[4:0] & BRIGHT_MASK;
                REG_BLANK_MODE: cfg_next.blank_mode = cfg.data[0];
                REG_END_FILL:   cfg_next.end_fill   = cfg.data[7:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_word <= 32'd0;
            cfg_reg.brightness <= 5'd1;
            cfg_reg.blank_mode <= 1'b0;
            cfg_reg.end_fill   <= FILL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_q = cfg_reg;

endmodule

FILE: sv/lsfe_front.sv
// Front end of the LED strip frame encoder: accepts items and classifies them.
// Depends on lsfe_pkg and lsfe_item_if; feeds the command queue.
module lsfe_front (
    lsfe_item_if.sink         item,
    input  lsfe_pkg::cfg_t    cfg_q,
    input  logic              q_full,
    output logic              q_push,
    output lsfe_pkg::cmd_t    q_cmd
);
    import lsfe_pkg::*;

    logic [4:0] bright;
    logic [7:0] top_byte;

    // An item is taken whenever the queue has room.
    assign item.ready = !q_full;
    assign q_push     = item.valid && !q_full;

    // A brightness of zero is raised to the minimum of one.
    assign bright   = (cfg_q.brightness == 5'd0) ? 5'd1 : cfg_q.brightness;
    assign top_byte = (item.led_word[31:24] & TOP_KEEP_MASK) | {3'b000, bright};

    // Work out which phases the item needs and build its LED bytes.
    always_comb
    begin
        if (item.kind == KIND_EMPTY)
        begin
            q_cmd.has_start = 1'b1;
            q_cmd.has_led   = 1'b0;
            q_cmd.has_end   = 1'b1;
        end
        else
        begin
            q_cmd.has_start = item.first_led;
            q_cmd.has_led   = 1'b1;
            q_cmd.has_end   = item.last_led;
        end

        if (cfg_q.blank_mode)
        begin
            q_cmd.led_bytes = {BLANK_TOP, 24'd0};
        end
        else
        begin
            q_cmd.led_bytes = {top_byte, item.led_word[23:0]};
        end
    end

endmodule

FILE: sv/lsfe_cmd_fifo.sv
// Short command queue that decouples the front end from the byte sequencer.
// Depends on lsfe_pkg for the command type and the depth.
module lsfe_cmd_fifo (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  lsfe_pkg::cmd_t                   push_cmd,
    input  logic                             pop,
    output logic                             full,
    output logic                             not_empty,
    output lsfe_pkg::cmd_t                   head_cmd,
    output logic [lsfe_pkg::FIFO_CNT_W-1:0]  count
);
    import lsfe_pkg::*;

    cmd_t                  entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;

    assign full      = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

    // Pointer and occupancy update; the pointers wrap at the depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                        : wr_ptr_reg + FIFO_PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                        : rd_ptr_reg + FIFO_PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + FIFO_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: sv/lsfe_back.sv
// Back end of the LED strip frame encoder: steps through the start, LED and
// end phases of each command, one byte per cycle unless the output stalls. Depends on lsfe_pkg and lsfe_byte_if.
module lsfe_back (
    input  logic              clk,
    input  logic              rst_n,
    input  lsfe_pkg::cfg_t    cfg_q,
    input  logic              q_valid,
    input  lsfe_pkg::cmd_t    q_cmd,
    output logic              q_pop,
    lsfe_byte_if.source       result
);
    import lsfe_pkg::*;

    typedef enum logic [2:0] {
        PH_START = 3'b001,
        PH_LED   = 3'b010,
        PH_END   = 3'b100
    } phase_t;

    localparam logic HAS_FILL = (END_BYTES > 0);

    logic             busy_reg;
    logic             busy_next;
    phase_t           phase_reg;
    phase_t           phase_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    cmd_t             cmd_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       out_byte_reg;
    logic             out_end_reg;

    logic             out_free;
    logic             emit;
    logic             phase_last;
    logic             to_led;
    logic             to_end;
    logic             cmd_final;
    logic [1:0]       byte_sel;
    logic [7:0]       cur_byte;

    // A byte leaves the sequencer when the output register is free.
    assign out_free = !out_valid_reg || result.ready;
    assign emit     = busy_reg && out_free;

    // Byte selection and end-of-phase detection.
    always_comb
    begin
        byte_sel   = 2'(LED_BYTES - 1) - cnt_reg[1:0];
        cur_byte   = cfg_q.end_fill;
        phase_last = 1'b0;
        to_led     = 1'b0;
        to_end     = 1'b0;
        unique case (phase_reg)
            PH_START:
            begin
                cur_byte   = cfg_q.start_word[byte_sel*8 +: 8];
                phase_last = (cnt_reg == CNT_W'(START_BYTES - 1));
                to_led     = cmd_reg.has_led;
                to_end     = !cmd_reg.has_led && cmd_reg.has_end && HAS_FILL;
            end
            PH_LED:
            begin
                cur_byte   = cmd_reg.led_bytes[byte_sel*8 +: 8];
                phase_last = (cnt_reg == CNT_W'(LED_BYTES - 1));
                to_end     = cmd_reg.has_end && HAS_FILL;
            end
            PH_END:
            begin
                cur_byte   = cfg_q.end_fill;
                phase_last = (cnt_reg == CNT_W'(END_LAST));
            end
            default:
            begin
                cur_byte   = cfg_q.end_fill;
                phase_last = 1'b1;
            end
        endcase
        cmd_final = phase_last && !to_led && !to_end;
    end

    // Take the next command when idle or on the final byte of the current one.
    assign q_pop = q_valid && (!busy_reg || (emit && cmd_final));

    // Sequencer state update.
    always_comb
    begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        if (q_pop)
        begin
            busy_next  = 1'b1;
            phase_next = q_cmd.has_start ? PH_START : PH_LED;
            cnt_next   = '0;
        end
        else if (emit && cmd_final)
        begin
            busy_next = 1'b0;
        end
        else if (emit && phase_last)
        begin
            phase_next = to_led ? PH_LED : PH_END;
            cnt_next   = '0;
        end
        else if (emit)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= PH_START;
            cnt_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_cmd;
        end
    end

    // Output register: holds a byte until the sink takes it.
    assign out_valid_next = out_free ? emit : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= cur_byte;
            out_end_reg  <= cmd_final && cmd_reg.has_end;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.out_byte  = out_byte_reg;
    assign result.frame_end = out_end_reg;

endmodule

FILE: sv/led_strip_frame_encoder.sv
// Top level of the LED strip frame encoder.
// Depends on lsfe_pkg, the three channel interfaces, lsfe_cfg_regs, lsfe_front,
// lsfe_cmd_fifo and lsfe_back.
//
// Turns LED words into the byte stream of an APA102-style strip. Each LED word
// gives four bytes, one byte per cycle while the output is not stalled; an LED
// that opens a frame is preceded by the four start-frame bytes, and one that
// closes it is followed by the 56 end-fill bytes, the final byte carrying
// frame_end. An empty-frame item gives only the start frame and the end fill.
// The rate is set by the single byte sequencer in the back end; a two-entry
// command queue lets the input side run ahead of it. Configuration is taken at
// any time but must only be written while no words are in flight.
module led_strip_frame_encoder (
    input  logic         clk,
    input  logic         rst_n,
    lsfe_item_if.sink    item,
    lsfe_byte_if.source  result,
    lsfe_cfg_if.sink     cfg
);
    import lsfe_pkg::*;

    cfg_t                  cfg_q;
    logic                  q_full;
    logic                  q_push;
    cmd_t                  q_push_cmd;
    logic                  q_pop;
    logic                  q_not_empty;
    cmd_t                  q_head_cmd;
    logic [FIFO_CNT_W-1:0] q_count;

    // Configuration registers.
    lsfe_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    // Front end: accept and classify.
    lsfe_front u_front (
        .item   (item),
        .cfg_q  (cfg_q),
        .q_full (q_full),
        .q_push (q_push),
        .q_cmd  (q_push_cmd)
    );

    // Command queue.
    lsfe_cmd_fifo u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_push_cmd),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_cmd  (q_head_cmd),
        .count     (q_count)
    );

    // Back end: byte sequencer and output register.
    lsfe_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_q   (cfg_q),
        .q_valid (q_not_empty),
        .q_cmd   (q_head_cmd),
        .q_pop   (q_pop),
        .result  (result)
    );

    // The sequencer only takes a command that is really queued.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_count != '0)
    else $error("command taken from an empty queue");

    // An accepted item is waiting in the queue on the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |=> q_count != '0)
    else $error("accepted item missing from the queue");

    // With an end fill, the flagged word is always a fill byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.frame_end) |->
            (END_BYTES == 0) || (result.out_byte == cfg_q.end_fill))
    else $error("frame end flagged on a byte other than the end fill");

endmodule
